/* hdl/ali_pkg.sv */
package ali_pkg;

    localparam int POSITION_BITS   = 32;
    localparam int ANGLE_FRAC_BITS = 16;
    localparam int ANGLE_BITS      = ANGLE_FRAC_BITS + 3;
    localparam int WRAP_BITS       = ANGLE_BITS + 1;
    localparam int DIFF_BITS       = POSITION_BITS + 1;
    localparam int MAG_BITS        = WRAP_BITS + POSITION_BITS + 1;
    localparam int NUM_BITS        = MAG_BITS + 1;

    localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
    localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
    localparam logic [63:0] TWO_PI_WIDE =
        ((TWO_PI_Q60 >> (59 - ANGLE_FRAC_BITS)) + 64'd1) >> 1;
    localparam logic [63:0] PI_WIDE =
        ((PI_Q60 >> (59 - ANGLE_FRAC_BITS)) + 64'd1) >> 1;
    localparam logic [ANGLE_BITS-1:0] TWO_PI = TWO_PI_WIDE[ANGLE_BITS-1:0];
    localparam logic [ANGLE_BITS-1:0] PI_Q   = PI_WIDE[ANGLE_BITS-1:0];

    typedef struct packed {
        logic [POSITION_BITS-1:0] query_position;
        logic [POSITION_BITS-1:0] start_position;
        logic [ANGLE_BITS-1:0]    start_inclination;
        logic [ANGLE_BITS-1:0]    start_azimuth;
        logic [POSITION_BITS-1:0] end_position;
        logic [ANGLE_BITS-1:0]    end_inclination;
        logic [ANGLE_BITS-1:0]    end_azimuth;
    } in_item_t;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] interpolated_inclination;
        logic [ANGLE_BITS-1:0] interpolated_azimuth;
    } out_item_t;

    // Per-angle state of the long division and the running residue modulo 2pi.
    typedef struct packed {
        logic [MAG_BITS-1:0]      mag;
        logic [POSITION_BITS-1:0] rem;
        logic                     qbit;
        logic [ANGLE_BITS-1:0]    res;
        logic                     negative;
        logic                     use_fb;
        logic [ANGLE_BITS-1:0]    fb;
    } lane_t;

    typedef struct packed {
        lane_t                    inc;
        lane_t                    az;
        logic [POSITION_BITS-1:0] dx;
    } div_word_t;

endpackage

/* hdl/ali_front.sv */
module ali_front
    import ali_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      item_valid,
    input  in_item_t  item,
    output logic      word_valid,
    output div_word_t word
);

    typedef struct packed {
        logic [WRAP_BITS-1:0] wa1;
        logic [WRAP_BITS-1:0] wa2;
    } pair_t;

    typedef struct packed {
        pair_t                        inc;
        pair_t                        az;
        logic signed [DIFF_BITS-1:0]  d1;
        logic signed [DIFF_BITS-1:0]  d2;
        logic [POSITION_BITS-1:0]     dx;
        logic                         spacing_ok;
        logic                         inc1_zero;
        logic                         inc2_nonzero;
        logic [ANGLE_BITS-1:0]        az2;
    } s1_t;

    typedef struct packed {
        logic signed [NUM_BITS-1:0] p1;
        logic signed [NUM_BITS-1:0] p2;
        logic                       use_fb;
        logic [ANGLE_BITS-1:0]      fb;
    } prod_t;

    typedef struct packed {
        prod_t                    inc;
        prod_t                    az;
        logic [POSITION_BITS-1:0] dx;
    } s2_t;

    typedef struct packed {
        logic signed [NUM_BITS-1:0] num;
        logic                       use_fb;
        logic [ANGLE_BITS-1:0]      fb;
    } sum_t;

    typedef struct packed {
        sum_t                     inc;
        sum_t                     az;
        logic [POSITION_BITS-1:0] dx;
    } s3_t;

    // When the two angles are more than pi apart, the smaller one is moved up by 2pi.
    function automatic pair_t wrap_angles(input logic [ANGLE_BITS-1:0] a1,
                                          input logic [ANGLE_BITS-1:0] a2);
        logic [ANGLE_BITS:0] up;
        logic [ANGLE_BITS:0] down;
        pair_t               r;
        up    = {1'b0, a2} - {1'b0, a1};
        down  = {1'b0, a1} - {1'b0, a2};
        r.wa1 = {1'b0, a1};
        r.wa2 = {1'b0, a2};
        if (!up[ANGLE_BITS] && (up[ANGLE_BITS-1:0] > PI_Q))
        begin
            r.wa1 = {1'b0, a1} + {1'b0, TWO_PI};
        end
        else if (!down[ANGLE_BITS] && (down[ANGLE_BITS-1:0] > PI_Q))
        begin
            r.wa2 = {1'b0, a2} + {1'b0, TWO_PI};
        end
        return r;
    endfunction

    // The wrapped angle stays below three times 2pi, so two candidate subtractions suffice.
    function automatic logic [ANGLE_BITS-1:0] mod_two_pi(input logic [WRAP_BITS-1:0] w);
        logic [WRAP_BITS-1:0] once;
        logic [WRAP_BITS-1:0] twice;
        logic [WRAP_BITS-1:0] r;
        once  = {1'b0, TWO_PI};
        twice = {TWO_PI, 1'b0};
        if (w >= twice)
        begin
            r = w - twice;
        end
        else if (w >= once)
        begin
            r = w - once;
        end
        else
        begin
            r = w;
        end
        return r[ANGLE_BITS-1:0];
    endfunction

    function automatic lane_t start_lane(input sum_t s);
        logic [NUM_BITS-1:0] absval;
        lane_t               l;
        absval     = s.num[NUM_BITS-1] ? (~s.num + 1'b1) : s.num;
        l.mag      = absval[MAG_BITS-1:0];
        l.rem      = '0;
        l.qbit     = 1'b0;
        l.res      = '0;
        l.negative = s.num[NUM_BITS-1];
        l.use_fb   = s.use_fb;
        l.fb       = s.fb;
        return l;
    endfunction

    logic      s1_valid_reg;
    logic      s2_valid_reg;
    logic      s3_valid_reg;
    logic      s4_valid_reg;
    s1_t       s1_reg;
    s1_t       s1_next;
    s2_t       s2_reg;
    s2_t       s2_next;
    s3_t       s3_reg;
    s3_t       s3_next;
    div_word_t s4_reg;
    div_word_t s4_next;

    always_comb
    begin
        s1_next.inc = wrap_angles(item.start_inclination, item.end_inclination);
        s1_next.az  = wrap_angles(item.start_azimuth, item.end_azimuth);
        s1_next.d1  = $signed({1'b0, item.end_position}) - $signed({1'b0, item.query_position});
        s1_next.d2  = $signed({1'b0, item.query_position}) - $signed({1'b0, item.start_position});
        s1_next.dx  = item.end_position - item.start_position;
        s1_next.spacing_ok   = item.end_position > item.start_position;
        s1_next.inc1_zero    = item.start_inclination == '0;
        s1_next.inc2_nonzero = item.end_inclination != '0;
        s1_next.az2          = item.end_azimuth;
    end

    always_comb
    begin
        s2_next.inc.p1     = $signed({1'b0, s1_reg.inc.wa1}) * $signed(s1_reg.d1);
        s2_next.inc.p2     = $signed({1'b0, s1_reg.inc.wa2}) * $signed(s1_reg.d2);
        s2_next.inc.use_fb = !s1_reg.spacing_ok;
        s2_next.inc.fb     = mod_two_pi(s1_reg.inc.wa2);
        s2_next.az.p1      = $signed({1'b0, s1_reg.az.wa1}) * $signed(s1_reg.d1);
        s2_next.az.p2      = $signed({1'b0, s1_reg.az.wa2}) * $signed(s1_reg.d2);
        s2_next.az.use_fb  = !s1_reg.spacing_ok || s1_reg.inc1_zero;
        if (s1_reg.inc1_zero)
        begin
            s2_next.az.fb = s1_reg.inc2_nonzero ? s1_reg.az2 : '0;
        end
        else
        begin
            s2_next.az.fb = mod_two_pi(s1_reg.az.wa2);
        end
        s2_next.dx = s1_reg.dx;
    end

    always_comb
    begin
        s3_next.inc.num    = s2_reg.inc.p1 + s2_reg.inc.p2;
        s3_next.inc.use_fb = s2_reg.inc.use_fb;
        s3_next.inc.fb     = s2_reg.inc.fb;
        s3_next.az.num     = s2_reg.az.p1 + s2_reg.az.p2;
        s3_next.az.use_fb  = s2_reg.az.use_fb;
        s3_next.az.fb      = s2_reg.az.fb;
        s3_next.dx         = s2_reg.dx;
    end

    always_comb
    begin
        s4_next.inc = start_lane(s3_reg.inc);
        s4_next.az  = start_lane(s3_reg.az);
        s4_next.dx  = s3_reg.dx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= item_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
        end
    end

    assign word_valid = s4_valid_reg;
    assign word       = s4_reg;

endmodule

/* hdl/ali_div_stage.sv */
module ali_div_stage
    import ali_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      word_valid,
    input  div_word_t word,
    output logic      step_valid,
    output div_word_t step_word
);

    // One quotient bit of the division by the spacing, and one earlier quotient bit
    // folded into the residue modulo 2pi.
    function automatic lane_t step_lane(input lane_t l, input logic [POSITION_BITS-1:0] dx);
        logic [POSITION_BITS:0] shifted;
        logic [POSITION_BITS:0] diff;
        logic [ANGLE_BITS:0]    rs;
        logic [ANGLE_BITS:0]    rd;
        lane_t                  r;
        r       = l;
        shifted = {l.rem, l.mag[MAG_BITS-1]};
        diff    = shifted - {1'b0, dx};
        r.mag   = {l.mag[MAG_BITS-2:0], 1'b0};
        if (shifted >= {1'b0, dx})
        begin
            r.rem  = diff[POSITION_BITS-1:0];
            r.qbit = 1'b1;
        end
        else
        begin
            r.rem  = shifted[POSITION_BITS-1:0];
            r.qbit = 1'b0;
        end
        rs    = {l.res, l.qbit};
        rd    = rs - {1'b0, TWO_PI};
        r.res = (rs >= {1'b0, TWO_PI}) ? rd[ANGLE_BITS-1:0] : rs[ANGLE_BITS-1:0];
        return r;
    endfunction

    logic      valid_reg;
    div_word_t word_reg;
    div_word_t word_next;

    always_comb
    begin
        word_next.inc = step_lane(word.inc, word.dx);
        word_next.az  = step_lane(word.az, word.dx);
        word_next.dx  = word.dx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= word_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign step_valid = valid_reg;
    assign step_word  = word_reg;

endmodule

/* hdl/ali_back.sv */
module ali_back
    import ali_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      word_valid,
    input  div_word_t word,
    output logic      result_valid,
    output out_item_t result
);

    // Folds in the last quotient bit, applies the sign, or returns the fallback.
    function automatic logic [ANGLE_BITS-1:0] finish_lane(input lane_t l);
        logic [ANGLE_BITS:0]   rs;
        logic [ANGLE_BITS:0]   rd;
        logic [ANGLE_BITS-1:0] r;
        logic [ANGLE_BITS-1:0] v;
        rs = {l.res, l.qbit};
        rd = rs - {1'b0, TWO_PI};
        r  = (rs >= {1'b0, TWO_PI}) ? rd[ANGLE_BITS-1:0] : rs[ANGLE_BITS-1:0];
        v  = (l.negative && (r != '0)) ? (TWO_PI - r) : r;
        return l.use_fb ? l.fb : v;
    endfunction

    logic      valid_reg;
    out_item_t result_reg;
    out_item_t result_next;

    always_comb
    begin
        result_next.interpolated_inclination = finish_lane(word.inc);
        result_next.interpolated_azimuth     = finish_lane(word.az);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= word_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

/* hdl/angle_linear_interpolation_unit.sv */
// Interpolates the inclination and azimuth of a survey trajectory at a query position
// between two stations. A transaction on the query channel carries the query position
// and both stations; a transaction on the result channel carries the two angles.
// Each channel moves a transaction at a rising edge where its valid is high and its
// stall is low. Every query gives exactly one result, in order.
// Four front stages (angle wrap and differences, the two products, their sum, the magnitude),
// one stage per quotient bit of the long division by the station spacing (53 stages, each
// also folding one quotient bit into the residue modulo 2pi), one final stage and the output
// register lie between the accepting edge and result_valid. A new query is accepted in every
// cycle in which query_stall is low, so the sustained rate is one transaction per cycle while
// the pipeline does not freeze.
// When the receiver stalls, the result register holds its transaction, and the pipeline
// keeps moving as long as the stage behind the output register holds no transaction;
// otherwise it freezes and query_stall rises until the result is taken.
// Reset empties the pipeline and the result register. Outside reset, no transaction is lost or repeated.
module angle_linear_interpolation_unit
    import ali_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      query_valid,
    output logic      query_stall,
    input  in_item_t  query,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    logic                en;
    logic [MAG_BITS:0]   chain_valid;
    div_word_t           chain_word [0:MAG_BITS];
    logic                back_valid;
    out_item_t           back_item;
    logic                out_load;
    logic                result_valid_reg;
    out_item_t           result_item_reg;

    assign en          = !(result_valid_reg && result_stall && back_valid);
    assign query_stall = !en;
    assign out_load    = !result_valid_reg || !result_stall;

    ali_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .item_valid (query_valid),
        .item       (query),
        .word_valid (chain_valid[0]),
        .word       (chain_word[0])
    );

    genvar g;
    for (g = 0; g < MAG_BITS; g++)
    begin : g_div
        ali_div_stage u_stage (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .word_valid (chain_valid[g]),
            .word       (chain_word[g]),
            .step_valid (chain_valid[g+1]),
            .step_word  (chain_word[g+1])
        );
    end

    ali_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .word_valid   (chain_valid[MAG_BITS]),
        .word         (chain_word[MAG_BITS]),
        .result_valid (back_valid),
        .result       (back_item)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            result_valid_reg <= back_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result_item_reg <= back_item;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_item_reg;

    property p_stall_only_when_full;
        @(posedge clk) disable iff (!rst_n)
        query_stall |-> (back_valid && result_valid_reg);
    endproperty
    a_stall_only_when_full : assert property (p_stall_only_when_full)
        else $error("Query channel stalled while the pipeline tail could still move.");

    property p_tail_held;
        @(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_stall && back_valid) |=> (back_valid && $stable(back_item));
    endproperty
    a_tail_held : assert property (p_tail_held)
        else $error("Pipeline tail changed while the result register was blocked.");

    property p_inclination_reduced;
        @(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (result_item_reg.interpolated_inclination < TWO_PI);
    endproperty
    a_inclination_reduced : assert property (p_inclination_reduced)
        else $error("Interpolated inclination is not reduced below 2pi.");

endmodule

/* bench/angle_linear_interpolation_unit_tb.sv */
module angle_linear_interpolation_unit_tb;
    import ali_pkg::*;

    localparam logic [ANGLE_BITS:0]      ANGLE_TURN      = 20'd411775;
    localparam logic [ANGLE_BITS:0]      ANGLE_HALF_TURN = 20'd205887;
    localparam logic [POSITION_BITS-1:0] POS_MAX         = '1;
    localparam logic [ANGLE_BITS-1:0]    CODE_MAX        = '1;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      query_valid  = 1'b0;
    logic      query_stall;
    in_item_t  query        = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result;

    out_item_t pending_angles[$];
    out_item_t oldest_angles;
    int        mismatch_count  = 0;
    int        queries_sent    = 0;
    int        results_checked = 0;
    int        spacing_cases   = 0;
    int        vertical_cases  = 0;
    int        stall_left      = 0;
    bit        sender_idle_on  = 1'b0;
    bit        stall_on        = 1'b0;

    angle_linear_interpolation_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .query_valid  (query_valid),
        .query_stall  (query_stall),
        .query        (query),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #5 clk = ~clk;

    function automatic logic [ANGLE_BITS-1:0] interpolate_angle(
        input logic [POSITION_BITS-1:0] xq,
        input logic [POSITION_BITS-1:0] x1,
        input logic [ANGLE_BITS-1:0]    a1_code,
        input logic [POSITION_BITS-1:0] x2,
        input logic [ANGLE_BITS-1:0]    a2_code
    );
        logic [ANGLE_BITS:0] a1;
        logic [ANGLE_BITS:0] a2;
        logic signed [127:0] xq_w;
        logic signed [127:0] x1_w;
        logic signed [127:0] x2_w;
        logic signed [127:0] a1_w;
        logic signed [127:0] a2_w;
        logic signed [127:0] turn_w;
        logic signed [127:0] quo;
        logic signed [127:0] residue;
        a1 = {1'b0, a1_code};
        a2 = {1'b0, a2_code};
        if (a2 > a1 && a2 - a1 > ANGLE_HALF_TURN)
            a1 = a1 + ANGLE_TURN;
        else if (a1 > a2 && a1 - a2 > ANGLE_HALF_TURN)
            a2 = a2 + ANGLE_TURN;
        if (x2 <= x1)
        begin
            a2 = a2 % ANGLE_TURN;
            return a2[ANGLE_BITS-1:0];
        end
        xq_w   = 128'(xq);
        x1_w   = 128'(x1);
        x2_w   = 128'(x2);
        a1_w   = 128'(a1);
        a2_w   = 128'(a2);
        turn_w = 128'(ANGLE_TURN);
        quo = (a1_w * (x2_w - xq_w) + a2_w * (xq_w - x1_w)) / (x2_w - x1_w);
        residue = quo % turn_w;
        if (residue < 0)
            residue = residue + turn_w;
        return residue[ANGLE_BITS-1:0];
    endfunction

    function automatic out_item_t predict_angles(input in_item_t q);
        out_item_t r;
        r.interpolated_inclination = interpolate_angle(q.query_position, q.start_position,
            q.start_inclination, q.end_position, q.end_inclination);
        if (q.start_inclination == '0)
            r.interpolated_azimuth = (q.end_inclination != '0) ? q.end_azimuth : '0;
        else
            r.interpolated_azimuth = interpolate_angle(q.query_position, q.start_position,
                q.start_azimuth, q.end_position, q.end_azimuth);
        return r;
    endfunction

    function automatic in_item_t mk_query(
        input logic [POSITION_BITS-1:0] xq,
        input logic [POSITION_BITS-1:0] x1,
        input logic [ANGLE_BITS-1:0]    inc1,
        input logic [ANGLE_BITS-1:0]    az1,
        input logic [POSITION_BITS-1:0] x2,
        input logic [ANGLE_BITS-1:0]    inc2,
        input logic [ANGLE_BITS-1:0]    az2
    );
        in_item_t q;
        q.query_position    = xq;
        q.start_position    = x1;
        q.start_inclination = inc1;
        q.start_azimuth     = az1;
        q.end_position      = x2;
        q.end_inclination   = inc2;
        q.end_azimuth       = az2;
        return q;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(13, 60);
    endfunction

    function automatic logic [ANGLE_BITS-1:0] random_angle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return ANGLE_BITS'($urandom_range(0, 411774));
        else if (r < 95)
            return ANGLE_BITS'($urandom_range(411775, 524287));
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return 19'd1;
            2:       return 19'd411774;
            default: return CODE_MAX;
        endcase
    endfunction

    function automatic in_item_t random_query(input bit well_formed);
        in_item_t q;
        logic [POSITION_BITS-1:0] dx;
        logic [POSITION_BITS-1:0] off;
        int r;
        if (!well_formed)
        begin
            q.query_position    = $urandom;
            q.start_position    = $urandom;
            q.start_inclination = ANGLE_BITS'($urandom_range(0, 524287));
            q.start_azimuth     = ANGLE_BITS'($urandom_range(0, 524287));
            q.end_position      = $urandom;
            q.end_inclination   = ANGLE_BITS'($urandom_range(0, 524287));
            q.end_azimuth       = ANGLE_BITS'($urandom_range(0, 524287));
            return q;
        end
        r = $urandom_range(0, 99);
        if (r < 40)
            dx = $urandom_range(1000, 1);
        else if (r < 80)
            dx = $urandom_range(32'h0010_0000, 1);
        else
            dx = $urandom_range(32'hFFFF_FFFF, 1);
        q.start_position = $urandom;
        if (q.start_position > POS_MAX - dx)
            q.start_position = POS_MAX - dx;
        q.end_position = q.start_position + dx;
        off = $urandom_range(dx, 0);
        r = $urandom_range(0, 99);
        if (r < 80)
            q.query_position = q.start_position + off;
        else if (r < 90)
            q.query_position = (off > q.start_position) ? '0 : q.start_position - off;
        else
            q.query_position = (off > POS_MAX - q.end_position) ? POS_MAX
                                                                : q.end_position + off;
        if ($urandom_range(0, 99) < 5)
        begin
            q.end_position   = q.start_position;
            q.start_position = q.start_position + (($urandom_range(0, 1) == 1) ? off : '0);
        end
        q.start_inclination = ($urandom_range(0, 99) < 8) ? '0 : random_angle();
        q.start_azimuth     = random_angle();
        q.end_inclination   = ($urandom_range(0, 99) < 4) ? '0 : random_angle();
        q.end_azimuth       = random_angle();
        return q;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 25)
            $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    // Called at a negedge; returns at a negedge after the transaction and any gap.
    task automatic send_query(input in_item_t q);
        int gap;
        query       <= q;
        query_valid <= 1'b1;
        do
            @(posedge clk);
        while (query_stall);
        pending_angles.push_back(predict_angles(q));
        queries_sent++;
        if (q.end_position <= q.start_position)
            spacing_cases++;
        if (q.start_inclination == '0)
            vertical_cases++;
        @(negedge clk);
        gap = (sender_idle_on && $urandom_range(0, 99) < 35) ? pick_gap() : 0;
        if (gap > 0)
        begin
            query_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic wait_for_results();
        query_valid <= 1'b0;
        while (pending_angles.size() != 0)
            @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            result_stall <= 1'b1;
            stall_left   <= stall_left - 1;
        end
        else if (stall_on && $urandom_range(0, 99) < 20)
        begin
            result_stall <= 1'b1;
            stall_left   <= pick_gap() - 1;
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_angles.size() == 0)
            begin
                report_mismatch("result transaction with no outstanding query");
            end
            else
            begin
                oldest_angles = pending_angles.pop_front();
                results_checked++;
                if (result.interpolated_inclination !== oldest_angles.interpolated_inclination)
                    report_mismatch($sformatf("inclination got %0d expected %0d",
                        result.interpolated_inclination,
                        oldest_angles.interpolated_inclination));
                if (result.interpolated_azimuth !== oldest_angles.interpolated_azimuth)
                    report_mismatch($sformatf("azimuth got %0d expected %0d",
                        result.interpolated_azimuth, oldest_angles.interpolated_azimuth));
            end
        end
    end

    task automatic test_field_extremes();
        sender_idle_on = 1'b0;
        stall_on       = 1'b0;
        send_query(mk_query('0, '0, '0, '0, '0, '0, '0));
        send_query(mk_query(POS_MAX, POS_MAX, CODE_MAX, CODE_MAX, POS_MAX, CODE_MAX, CODE_MAX));
        send_query(mk_query('0, '0, CODE_MAX, CODE_MAX, POS_MAX, CODE_MAX, CODE_MAX));
        send_query(mk_query(POS_MAX, '0, CODE_MAX, CODE_MAX, POS_MAX, '0, '0));
        send_query(mk_query(POS_MAX, '0, 19'd411774, 19'd411774, 32'd1, '0, '0));
        send_query(mk_query(32'd1000, 32'd1000, 19'd100000, 19'd200000, 32'd3000,
                            19'd150000, 19'd250000));
        send_query(mk_query(32'd3000, 32'd1000, 19'd100000, 19'd200000, 32'd3000,
                            19'd150000, 19'd250000));
        send_query(mk_query(32'd2000, 32'd1000, 19'd100000, 19'd200000, 32'd3000,
                            19'd150000, 19'd250000));
        send_query(mk_query('0, 32'd1000, 19'd100000, 19'd100000, 32'd3000,
                            19'd300000, 19'd300000));
    endtask

    task automatic test_special_cases();
        send_query(mk_query(32'd500, '0, 19'd10, 19'd10, 32'd1000, 19'd400000, 19'd400000));
        send_query(mk_query(32'd500, '0, 19'd400000, 19'd400000, 32'd1000, 19'd10, 19'd10));
        send_query(mk_query(32'd500, '0, 19'd1, 19'd1, 32'd1000, 19'd205888, 19'd205888));
        send_query(mk_query(32'd500, '0, 19'd1, 19'd1, 32'd1000, 19'd205889, 19'd205889));
        send_query(mk_query(32'd500, 32'd1000, 19'd5, 19'd5, '0, 19'd400000, 19'd400000));
        send_query(mk_query(32'd7, 32'd9, 19'd400000, 19'd400000, 32'd9, 19'd10, 19'd10));
        send_query(mk_query(32'd500, '0, '0, 19'd300000, 32'd1000, 19'd5, CODE_MAX));
        send_query(mk_query(32'd500, '0, '0, 19'd300000, 32'd1000, '0, 19'd1234));
        send_query(mk_query(32'd5, 32'd5, '0, 19'd100, 32'd5, 19'd7, 19'd200));
        send_query(mk_query(32'd500, '0, 19'd450000, CODE_MAX, 32'd1000,
                            19'd411775, 19'd411776));
        send_query(mk_query('0, 32'd100, 19'd3, 19'd3, 32'd200, 19'd1000, 19'd1000));
        send_query(mk_query('0, 32'd1000, 19'd225, 19'd225, 32'd1001, 19'd637, 19'd637));
        wait_for_results();
    endtask

    task automatic test_back_to_back();
        sender_idle_on = 1'b0;
        stall_on       = 1'b0;
        repeat (300) send_query(random_query(1'b1));
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        sender_idle_on = 1'b1;
        stall_on       = 1'b1;
        for (int i = 0; i < 750; i++)
        begin
            if (i == 400)
                wait_for_results();
            send_query(random_query($urandom_range(0, 99) < 90));
        end
    endtask

    task automatic test_raw_fields();
        sender_idle_on = 1'b1;
        stall_on       = 1'b1;
        repeat (250) send_query(random_query(1'b0));
        wait_for_results();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_field_extremes();
        test_special_cases();
        test_back_to_back();
        test_random_traffic();
        test_raw_fields();
        wait_for_results();
        stall_on = 1'b0;
        repeat (70) @(posedge clk);
        $display("Sent %0d queries and checked %0d results, %0d with no forward spacing",
                 queries_sent, results_checked, spacing_cases);
        $display("and %0d with a vertical first station, under random idling and stalls.",
                 vertical_cases);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
